[rtl/gjsc_pkg.sv]
// Shared constants, types and lookup functions for the date/seconds converter.
`default_nettype none

package gjsc_pkg;

  localparam logic OP_TO_SECONDS = 1'b0;
  localparam logic OP_TO_DATE    = 1'b1;

  localparam logic [1:0] MODE_GREGORIAN = 2'd0;
  localparam logic [1:0] MODE_JULIAN    = 2'd1;
  localparam logic [1:0] MODE_NONE      = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_CONV = 2'd1;
  localparam logic [1:0] STATUS_RANGE   = 2'd2;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_SPD  = 1'b1;

  localparam int SPD_W = 17;
  localparam logic [SPD_W-1:0] SPD_RESET = 17'd86400;

  localparam int GREG_DAY_MAX = 536802342;

  localparam int DIV_BITS  = 64;
  localparam int INV_LAT   = 10;
  localparam int FWD_LAT   = 4;
  localparam int FWD_PAD   = INV_LAT - FWD_LAT;
  localparam int TOTAL_LAT = DIV_BITS + 2 + INV_LAT + 1;

  // floor(2^32 / d): quotient estimate low by at most one for dividends below 2^32
  localparam int RCP_SHIFT = 32;
  localparam logic [63:0] RCP_100     = (64'd1 << RCP_SHIFT) / 64'd100;
  localparam logic [63:0] RCP_146097  = (64'd1 << RCP_SHIFT) / 64'd146097;
  localparam logic [63:0] RCP_1461001 = (64'd1 << RCP_SHIFT) / 64'd1461001;
  localparam logic [63:0] RCP_2447    = (64'd1 << RCP_SHIFT) / 64'd2447;

  typedef struct packed {
    logic               op;
    logic signed [21:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic signed [31:0] julian_day;
  } item_t;

  typedef struct packed {
    logic signed [63:0] seconds;
    logic [1:0]         status;
  } fwd_res_t;

  typedef struct packed {
    logic signed [21:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic signed [31:0] julian_day;
    logic [1:0]         status;
  } inv_res_t;

  // (367 * (month - 2 - 12 * t)) / 12 with t = (month - 14) / 12
  function automatic logic [8:0] month_offset(input logic [3:0] mo);
    logic [8:0] r;
    case (mo)
      4'd0:    r = 9'd305;
      4'd1:    r = 9'd336;
      4'd2:    r = 9'd367;
      4'd3:    r = 9'd30;
      4'd4:    r = 9'd61;
      4'd5:    r = 9'd91;
      4'd6:    r = 9'd122;
      4'd7:    r = 9'd152;
      4'd8:    r = 9'd183;
      4'd9:    r = 9'd214;
      4'd10:   r = 9'd244;
      4'd11:   r = 9'd275;
      4'd12:   r = 9'd305;
      4'd13:   r = 9'd336;
      4'd14:   r = 9'd367;
      default: r = 9'd397;
    endcase
    return r;
  endfunction

  // (2447 * j) / 80
  function automatic logic [8:0] days_before(input logic [3:0] j);
    logic [8:0] r;
    case (j)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd152;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd305;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      default: r = 9'd458;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/gregorian_julian_seconds_converter.sv]
// Top level: calendar date / seconds converter with configuration registers.
`default_nettype none

// Fully pipelined: a transaction is taken in every cycle (busy stays low) and its
// result appears on the output ports with done high, in order. Each transaction
// passes through the seconds-per-day divider, which resolves one quotient bit
// per stage over 64 stages, and then the ten-stage date recovery path.
// Results cannot be held off; each is shown for a single cycle.
// Configuration writes are always taken (cfg_ready high) and apply to the
// whole pipeline, so they belong between transactions once done has drained.
module gregorian_julian_seconds_converter (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic                        cfg_index,
  input  wire logic [gjsc_pkg::SPD_W-1:0]  cfg_data,
  input  wire logic                        operation,
  input  wire logic signed [21:0]          year_in,
  input  wire logic [3:0]                  month_in,
  input  wire logic [4:0]                  day_in,
  input  wire logic signed [31:0]          julian_day_in,
  input  wire logic signed [63:0]          seconds_in,
  output logic                             done,
  output logic signed [63:0]               seconds_out,
  output logic signed [21:0]               year_out,
  output logic [3:0]                       month_out,
  output logic [4:0]                       day_out,
  output logic signed [31:0]               julian_day_out,
  output logic [1:0]                       status
);

  logic [1:0]                 mode;
  logic [gjsc_pkg::SPD_W-1:0] spd;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= gjsc_pkg::MODE_NONE;
      spd  <= gjsc_pkg::SPD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gjsc_pkg::CFG_MODE: mode <= cfg_data[1:0];
        gjsc_pkg::CFG_SPD:  spd  <= cfg_data;
        default:            mode <= mode;
      endcase
    end
  end

  logic            accept;
  gjsc_pkg::item_t in_item;

  assign accept             = start && !busy;
  assign in_item.op         = operation;
  assign in_item.year       = year_in;
  assign in_item.month      = month_in;
  assign in_item.day        = day_in;
  assign in_item.julian_day = julian_day_in;

  logic               div_valid;
  logic signed [63:0] div_quot;
  gjsc_pkg::item_t    div_item;

  gjsc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_secs   (seconds_in),
    .spd       (spd),
    .in_item   (in_item),
    .out_valid (div_valid),
    .out_quot  (div_quot),
    .out_item  (div_item)
  );

  logic               fwd_valid;
  gjsc_pkg::fwd_res_t fwd_res;

  gjsc_fwd u_fwd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_item   (div_item),
    .mode      (mode),
    .spd       (spd),
    .out_valid (fwd_valid),
    .out_res   (fwd_res)
  );

  logic               inv_valid;
  gjsc_pkg::inv_res_t inv_res;

  gjsc_inv u_inv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_jd     (div_quot),
    .in_op     (div_item.op),
    .mode      (mode),
    .spd       (spd),
    .out_valid (inv_valid),
    .out_res   (inv_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fwd_valid;
    end
    seconds_out    <= fwd_res.seconds;
    year_out       <= inv_res.year;
    month_out      <= inv_res.month;
    day_out        <= inv_res.day;
    julian_day_out <= inv_res.julian_day;
    status         <= fwd_res.status | inv_res.status;
  end

  a_paths_aligned: assert property (@(posedge clk) disable iff (rst)
    fwd_valid == inv_valid)
    else $error("date and seconds paths out of step");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept && !rst, gjsc_pkg::TOTAL_LAT))
    else $error("result without a matching transaction");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == gjsc_pkg::STATUS_NO_CONV || status == gjsc_pkg::STATUS_RANGE)
    |-> seconds_out == '0 && year_out == '0 && month_out == '0 && day_out == '0
        && julian_day_out == '0)
    else $error("failed conversion with nonzero fields");

endmodule

`default_nettype wire

[rtl/gjsc_div.sv]
// Pipelined restoring divider: seconds by seconds-per-day, one quotient bit per stage.
`default_nettype none

module gjsc_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic signed [63:0]          in_secs,
  input  wire logic [gjsc_pkg::SPD_W-1:0]  spd,
  input  wire gjsc_pkg::item_t             in_item,
  output logic                             out_valid,
  output logic signed [63:0]               out_quot,
  output gjsc_pkg::item_t                  out_item
);

  localparam int N = gjsc_pkg::DIV_BITS;
  localparam int R = gjsc_pkg::SPD_W;

  logic            vld [0:N];
  logic            neg [0:N];
  logic [R-1:0]    rem [0:N];
  logic [N-1:0]    acc [0:N];
  gjsc_pkg::item_t itm [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    neg[0] <= in_secs[N-1];
    acc[0] <= in_secs[N-1] ? N'(-in_secs) : N'(in_secs);
    rem[0] <= '0;
    itm[0] <= in_item;
  end

  for (genvar k = 0; k < N; k++) begin : g_bit
    logic [R:0] trial;
    logic       fits;

    assign trial = {rem[k], acc[k][N-1]};
    assign fits  = trial >= {1'b0, spd};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      rem[k+1] <= fits ? R'(trial - {1'b0, spd}) : trial[R-1:0];
      acc[k+1] <= {acc[k][N-2:0], fits};
      neg[k+1] <= neg[k];
      itm[k+1] <= itm[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[N];
    end
    out_quot <= neg[N] ? -$signed(acc[N]) : $signed(acc[N]);
    out_item <= itm[N];
  end

endmodule

`default_nettype wire

[rtl/gjsc_fwd.sv]
// Date to seconds: Fliegel-Van Flandern day number (Gregorian mode) or the given Julian day, scaled by seconds per day.
`default_nettype none

module gjsc_fwd (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire gjsc_pkg::item_t             in_item,
  input  wire logic [1:0]                  mode,
  input  wire logic [gjsc_pkg::SPD_W-1:0]  spd,
  output logic                             out_valid,
  output gjsc_pkg::fwd_res_t               out_res
);

  localparam int PAD = gjsc_pkg::FWD_PAD;

  // stage 1
  logic signed [23:0] t_c, a_c, c_c;
  logic [22:0]        c_abs_c;
  logic [63:0]        p100_c;
  logic               f1_v, f1_op, f1_cneg;
  logic [8:0]         f1_k;
  logic [4:0]         f1_day;
  logic signed [31:0] f1_jin;
  logic [22:0]        f1_cabs;
  logic [15:0]        f1_qe;
  logic signed [34:0] f1_t1raw;

  assign t_c     = (in_item.month <= 4'd2) ? -24'sd1 : 24'sd0;
  assign a_c     = 24'(in_item.year) + 24'sd4800 + t_c;
  assign c_c     = 24'(in_item.year) + 24'sd4900 + t_c;
  assign c_abs_c = c_c[23] ? 23'(-c_c) : 23'(c_c);
  assign p100_c  = 64'(c_abs_c) * gjsc_pkg::RCP_100;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else begin
      f1_v <= in_valid;
    end
    f1_op    <= in_item.op;
    f1_k     <= gjsc_pkg::month_offset(in_item.month);
    f1_day   <= in_item.day;
    f1_jin   <= in_item.julian_day;
    f1_cneg  <= c_c[23];
    f1_cabs  <= c_abs_c;
    f1_qe    <= p100_c[gjsc_pkg::RCP_SHIFT +: 16];
    f1_t1raw <= 35'(a_c) * 35'sd1461;
  end

  // stage 2
  logic               f2_v, f2_op, f2_cneg;
  logic [8:0]         f2_k;
  logic [4:0]         f2_day;
  logic signed [31:0] f2_jin;
  logic [22:0]        f2_cabs, f2_m;
  logic [15:0]        f2_qe;
  logic signed [34:0] f2_t1;

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_v <= 1'b0;
    end else begin
      f2_v <= f1_v;
    end
    f2_op   <= f1_op;
    f2_k    <= f1_k;
    f2_day  <= f1_day;
    f2_jin  <= f1_jin;
    f2_cneg <= f1_cneg;
    f2_cabs <= f1_cabs;
    f2_qe   <= f1_qe;
    f2_m    <= 23'(f1_qe * 16'd100);
    f2_t1   <= (f1_t1raw + (f1_t1raw[34] ? 35'sd3 : 35'sd0)) >>> 2;
  end

  // stage 3
  logic [15:0]        q_c;
  logic signed [16:0] qs_c;
  logic signed [19:0] t3_c, term3_c;
  logic signed [35:0] jd_c;
  logic               f3_v, f3_op, f3_okg;
  logic [28:0]        f3_jd;
  logic signed [31:0] f3_jin;

  assign q_c     = f2_qe + 16'((f2_cabs - f2_m) >= 23'd100);
  assign qs_c    = f2_cneg ? -$signed({1'b0, q_c}) : $signed({1'b0, q_c});
  assign t3_c    = 20'(qs_c) * 20'sd3;
  assign term3_c = (t3_c + (t3_c[19] ? 20'sd3 : 20'sd0)) >>> 2;
  assign jd_c    = 36'(f2_t1) + 36'($signed({1'b0, f2_k})) - 36'(term3_c)
                 + 36'($signed({1'b0, f2_day})) - 36'sd32075;

  always_ff @(posedge clk) begin
    if (rst) begin
      f3_v <= 1'b0;
    end else begin
      f3_v <= f2_v;
    end
    f3_op  <= f2_op;
    f3_okg <= !jd_c[35] && (jd_c[34:0] <= 35'(gjsc_pkg::GREG_DAY_MAX));
    f3_jd  <= jd_c[28:0];
    f3_jin <= f2_jin;
  end

  // stage 4
  logic signed [32:0] opnd_c;
  logic signed [50:0] prod_c;
  gjsc_pkg::fwd_res_t res_c;

  assign opnd_c = (mode == gjsc_pkg::MODE_GREGORIAN) ? $signed({4'b0, f3_jd}) : 33'(f3_jin);
  assign prod_c = 51'(opnd_c) * 51'($signed({1'b0, spd}));

  always_comb begin
    res_c = '0;
    if (f3_op == gjsc_pkg::OP_TO_SECONDS) begin
      if (mode == gjsc_pkg::MODE_GREGORIAN) begin
        if (f3_okg) begin
          res_c.seconds = 64'(prod_c);
        end else begin
          res_c.status = gjsc_pkg::STATUS_RANGE;
        end
      end else if (mode == gjsc_pkg::MODE_JULIAN) begin
        res_c.seconds = 64'(prod_c);
      end else begin
        res_c.status = gjsc_pkg::STATUS_NO_CONV;
      end
    end
  end

  logic               pv [0:PAD];
  gjsc_pkg::fwd_res_t pr [0:PAD];

  always_ff @(posedge clk) begin
    if (rst) begin
      pv[0] <= 1'b0;
    end else begin
      pv[0] <= f3_v;
    end
    pr[0] <= res_c;
  end

  for (genvar k = 0; k < PAD; k++) begin : g_pad
    always_ff @(posedge clk) begin
      if (rst) begin
        pv[k+1] <= 1'b0;
      end else begin
        pv[k+1] <= pv[k];
      end
      pr[k+1] <= pr[k];
    end
  end

  assign out_valid = pv[PAD];
  assign out_res   = pr[PAD];

endmodule

`default_nettype wire

[rtl/gjsc_inv.sv]
// Day number to calendar date: inverse Fliegel-Van Flandern, reciprocal dividers.
`default_nettype none

module gjsc_inv (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic signed [63:0]          in_jd,
  input  wire logic                        in_op,
  input  wire logic [1:0]                  mode,
  input  wire logic [gjsc_pkg::SPD_W-1:0]  spd,
  output logic                             out_valid,
  output gjsc_pkg::inv_res_t               out_res
);

  localparam int L = gjsc_pkg::INV_LAT;
  localparam int S = gjsc_pkg::RCP_SHIFT;

  typedef struct packed {
    logic               op;
    logic               okg;
    logic               okj;
    logic signed [31:0] jd32;
  } inv_tag_t;

  logic     vld [1:L-1];
  inv_tag_t tag [1:L-1];

  // stage 1
  logic [28:0] l0_c;
  logic [30:0] x1_c;
  logic [63:0] p1_c;
  logic [28:0] s1_l0;
  logic [30:0] s1_x1;
  logic [13:0] s1_ne;

  assign l0_c = 29'(in_jd[28:0] + 29'd68569);
  assign x1_c = {l0_c, 2'b00};
  assign p1_c = 64'(x1_c) * gjsc_pkg::RCP_146097;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[1] <= 1'b0;
    end else begin
      vld[1] <= in_valid;
    end
    tag[1].op   <= in_op;
    tag[1].okg  <= !in_jd[63] && (in_jd[62:0] <= 63'(gjsc_pkg::GREG_DAY_MAX));
    tag[1].okj  <= (&in_jd[63:31]) || !(|in_jd[63:31]);
    tag[1].jd32 <= in_jd[31:0];
    s1_l0 <= l0_c;
    s1_x1 <= x1_c;
    s1_ne <= p1_c[S +: 14];
  end

  for (genvar k = 1; k < L - 1; k++) begin : g_tag
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      tag[k+1] <= tag[k];
    end
  end

  // stage 2
  logic [28:0] s2_l0;
  logic [30:0] s2_x1, s2_m1;
  logic [13:0] s2_ne;

  always_ff @(posedge clk) begin
    s2_l0 <= s1_l0;
    s2_x1 <= s1_x1;
    s2_ne <= s1_ne;
    s2_m1 <= 31'(s1_ne * 31'd146097);
  end

  // stage 3
  logic        adj1_c;
  logic [31:0] mn_c;
  logic [13:0] s3_n;
  logic [16:0] s3_l1;

  assign adj1_c = (s2_x1 - s2_m1) >= 31'd146097;
  assign mn_c   = 32'(s2_m1) + (adj1_c ? 32'd146097 : 32'd0);

  always_ff @(posedge clk) begin
    s3_n  <= s2_ne + 14'(adj1_c);
    s3_l1 <= 17'(s2_l0 - 29'((mn_c + 32'd3) >> 2));
  end

  // stage 4
  logic [27:0]        s4_x2;
  logic signed [21:0] s4_yb;
  logic [16:0]        s4_l1;

  always_ff @(posedge clk) begin
    s4_x2 <= 28'((28'(s3_l1) + 28'd1) * 28'd4000);
    s4_yb <= (22'($signed({1'b0, s3_n})) - 22'sd49) * 22'sd100;
    s4_l1 <= s3_l1;
  end

  // stage 5
  logic [63:0]        p2_c;
  logic [6:0]         s5_ie;
  logic [27:0]        s5_x2;
  logic signed [21:0] s5_yb;
  logic [16:0]        s5_l1;

  assign p2_c = 64'(s4_x2) * gjsc_pkg::RCP_1461001;

  always_ff @(posedge clk) begin
    s5_ie <= p2_c[S +: 7];
    s5_x2 <= s4_x2;
    s5_yb <= s4_yb;
    s5_l1 <= s4_l1;
  end

  // stage 6
  logic [27:0]        s6_m2, s6_x2;
  logic [17:0]        s6_h2;
  logic [6:0]         s6_ie;
  logic signed [21:0] s6_yb;
  logic [16:0]        s6_l1;

  always_ff @(posedge clk) begin
    s6_m2 <= 28'(s5_ie * 28'd1461001);
    s6_h2 <= 18'(s5_ie * 18'd1461);
    s6_ie <= s5_ie;
    s6_x2 <= s5_x2;
    s6_yb <= s5_yb;
    s6_l1 <= s5_l1;
  end

  // stage 7
  logic               adj2_c;
  logic [17:0]        hi_c;
  logic [6:0]         s7_i;
  logic [9:0]         s7_l2;
  logic signed [21:0] s7_yb;

  assign adj2_c = (s6_x2 - s6_m2) >= 28'd1461001;
  assign hi_c   = s6_h2 + (adj2_c ? 18'd1461 : 18'd0);

  always_ff @(posedge clk) begin
    s7_i  <= s6_ie + 7'(adj2_c);
    s7_l2 <= 10'(s6_l1 - 17'(hi_c >> 2) + 17'd31);
    s7_yb <= s6_yb;
  end

  // stage 8
  logic [15:0]        x3_c;
  logic [63:0]        p3_c;
  logic [3:0]         s8_je;
  logic [15:0]        s8_x3;
  logic [9:0]         s8_l2;
  logic [6:0]         s8_i;
  logic signed [21:0] s8_yb;

  assign x3_c = 16'(s7_l2) * 16'd80;
  assign p3_c = 64'(x3_c) * gjsc_pkg::RCP_2447;

  always_ff @(posedge clk) begin
    s8_je <= p3_c[S +: 4];
    s8_x3 <= x3_c;
    s8_l2 <= s7_l2;
    s8_i  <= s7_i;
    s8_yb <= s7_yb;
  end

  // stage 9
  logic [15:0]        s9_m3, s9_x3;
  logic [3:0]         s9_je;
  logic [9:0]         s9_l2;
  logic [6:0]         s9_i;
  logic signed [21:0] s9_yb;

  always_ff @(posedge clk) begin
    s9_m3 <= 16'(s8_je * 16'd2447);
    s9_x3 <= s8_x3;
    s9_je <= s8_je;
    s9_l2 <= s8_l2;
    s9_i  <= s8_i;
    s9_yb <= s8_yb;
  end

  // stage 10
  logic               adj3_c, l3_c;
  logic [3:0]         j_c;
  inv_tag_t           tg;
  gjsc_pkg::inv_res_t res_c;

  assign adj3_c = (s9_x3 - s9_m3) >= 16'd2447;
  assign j_c    = s9_je + 4'(adj3_c);
  assign l3_c   = j_c >= 4'd11;
  assign tg     = tag[L-1];

  always_comb begin
    res_c = '0;
    if (tg.op == gjsc_pkg::OP_TO_DATE) begin
      if (mode == gjsc_pkg::MODE_GREGORIAN) begin
        if (spd == '0 || !tg.okg) begin
          res_c.status = gjsc_pkg::STATUS_RANGE;
        end else begin
          res_c.day   = 5'(s9_l2 - 10'(gjsc_pkg::days_before(j_c)));
          res_c.month = 4'(j_c + 4'd2 - (l3_c ? 4'd12 : 4'd0));
          res_c.year  = s9_yb + 22'($signed({1'b0, s9_i})) + (l3_c ? 22'sd1 : 22'sd0);
        end
      end else if (mode == gjsc_pkg::MODE_JULIAN) begin
        if (spd == '0 || !tg.okj) begin
          res_c.status = gjsc_pkg::STATUS_RANGE;
        end else begin
          res_c.julian_day = tg.jd32;
        end
      end else begin
        res_c.status = gjsc_pkg::STATUS_NO_CONV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[L-1];
    end
    out_res <= res_c;
  end

endmodule

`default_nettype wire

[verif/gjsc_checker.sv]
// Checker for the date/seconds converter: predicts each result and compares it.
`timescale 1ns / 1ps

module gjsc_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic                         busy,
  input  wire logic                         cfg_valid,
  input  wire logic                         cfg_ready,
  input  wire logic                         cfg_index,
  input  wire logic [gjsc_pkg::SPD_W-1:0]   cfg_data,
  input  wire logic                         operation,
  input  wire logic signed [21:0]           year_in,
  input  wire logic [3:0]                   month_in,
  input  wire logic [4:0]                   day_in,
  input  wire logic signed [31:0]           julian_day_in,
  input  wire logic signed [63:0]           seconds_in,
  input  wire logic                         done,
  input  wire logic signed [63:0]           seconds_out,
  input  wire logic signed [21:0]           year_out,
  input  wire logic [3:0]                   month_out,
  input  wire logic [4:0]                   day_out,
  input  wire logic signed [31:0]           julian_day_out,
  input  wire logic [1:0]                   status,
  output int                                errors,
  output int                                pending
);

  typedef struct {
    logic signed [63:0] seconds;
    logic signed [21:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic signed [31:0] julian_day;
    logic [1:0]         status;
  } conv_t;

  logic [1:0]                 mode_q;
  logic [gjsc_pkg::SPD_W-1:0] spd_q;
  conv_t                      expected_q[$];

  function automatic conv_t convert(input logic op, input longint yr, input longint mo,
                                    input longint dy, input longint jin,
                                    input longint secs, input logic [1:0] mode,
                                    input longint spd);
    conv_t  r;
    longint t, jd, l, n, i, j;
    r = '{default: '0};
    r.status = gjsc_pkg::STATUS_OK;
    if (mode == gjsc_pkg::MODE_GREGORIAN) begin
      if (op == gjsc_pkg::OP_TO_SECONDS) begin
        t = (mo - 14) / 12;
        jd = (1461 * (yr + 4800 + t)) / 4 + (367 * (mo - 2 - 12 * t)) / 12
             - (3 * ((yr + 4900 + t) / 100)) / 4 + dy - 32075;
        if (jd < 0 || jd > gjsc_pkg::GREG_DAY_MAX) r.status = gjsc_pkg::STATUS_RANGE;
        else r.seconds = jd * spd;
      end else if (spd == 0) begin
        r.status = gjsc_pkg::STATUS_RANGE;
      end else begin
        jd = secs / spd;
        if (jd < 0 || jd > gjsc_pkg::GREG_DAY_MAX) begin
          r.status = gjsc_pkg::STATUS_RANGE;
        end else begin
          l = jd + 68569;
          n = (4 * l) / 146097;
          l = l - (146097 * n + 3) / 4;
          i = (4000 * (l + 1)) / 1461001;
          l = l - (1461 * i) / 4 + 31;
          j = (80 * l) / 2447;
          r.day = 5'(l - (2447 * j) / 80);
          l = j / 11;
          r.month = 4'(j + 2 - 12 * l);
          r.year = 22'(100 * (n - 49) + i + l);
        end
      end
    end else if (mode == gjsc_pkg::MODE_JULIAN) begin
      if (op == gjsc_pkg::OP_TO_SECONDS) begin
        r.seconds = jin * spd;
      end else if (spd == 0) begin
        r.status = gjsc_pkg::STATUS_RANGE;
      end else begin
        jd = secs / spd;
        if (jd < -64'sd2147483648 || jd > 64'sd2147483647) r.status = gjsc_pkg::STATUS_RANGE;
        else r.julian_day = 32'(jd);
      end
    end else begin
      r.status = gjsc_pkg::STATUS_NO_CONV;
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    conv_t e;
    if (rst) begin
      mode_q <= gjsc_pkg::MODE_NONE;
      spd_q <= gjsc_pkg::SPD_RESET;
      expected_q.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gjsc_pkg::CFG_MODE) mode_q <= cfg_data[1:0];
        else spd_q <= cfg_data;
      end
      if (start && !busy)
        expected_q.push_back(convert(operation, longint'(year_in), longint'(month_in),
                                     longint'(day_in), longint'(julian_day_in),
                                     longint'(seconds_in), mode_q, longint'(spd_q)));
      if (done) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, status %0d", $time, status);
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.seconds !== seconds_out || e.year !== year_out || e.month !== month_out ||
              e.day !== day_out || e.julian_day !== julian_day_out ||
              e.status !== status) begin
            $display("%0t: mismatch expected sec %0d yr %0d mo %0d dy %0d jd %0d st %0d",
                     $time, e.seconds, e.year, e.month, e.day, e.julian_day, e.status);
            $display("%0t:            actual sec %0d yr %0d mo %0d dy %0d jd %0d st %0d",
                     $time, seconds_out, year_out, month_out, day_out, julian_day_out,
                     status);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

[verif/gregorian_julian_seconds_converter_test.sv]
// Testbench top: stimulus, configuration phases and verdict for the converter.
`timescale 1ns / 1ps

module gregorian_julian_seconds_converter_test;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic                       cfg_index;
  logic [gjsc_pkg::SPD_W-1:0] cfg_data;
  logic                       operation;
  logic signed [21:0]         year_in;
  logic [3:0]                 month_in;
  logic [4:0]                 day_in;
  logic signed [31:0]         julian_day_in;
  logic signed [63:0]         seconds_in;
  logic                       done;
  logic signed [63:0]         seconds_out;
  logic signed [21:0]         year_out;
  logic [3:0]                 month_out;
  logic [4:0]                 day_out;
  logic signed [31:0]         julian_day_out;
  logic [1:0]                 status;
  int                         errors;
  int                         pending;
  logic [gjsc_pkg::SPD_W-1:0] spd_now;
  bit                         calm;

  gregorian_julian_seconds_converter i_dut (.*);

  gjsc_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("** gregorian_julian_seconds_converter: FAILED **");
    $finish;
  end

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic idx, input logic [gjsc_pkg::SPD_W-1:0] value);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    forever begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
      if (ok) break;
    end
    if (idx == gjsc_pkg::CFG_SPD) spd_now = value;
  endtask

  task automatic send(input logic op, input logic signed [21:0] yr, input logic [3:0] mo,
                      input logic [4:0] dy, input logic signed [31:0] jin,
                      input logic signed [63:0] secs);
    bit ok;
    start <= 1'b1;
    operation <= op;
    year_in <= yr;
    month_in <= mo;
    day_in <= dy;
    julian_day_in <= jin;
    seconds_in <= secs;
    forever begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
      if (ok) break;
    end
    if (!calm && $urandom_range(5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(18, 1)) @(posedge clk);
    end
  endtask

  task automatic directed_items();
    longint spd;
    spd = longint'(spd_now);
    send(gjsc_pkg::OP_TO_SECONDS, -22'sd4713, 4'd11, 5'd24, 32'sd0, 64'sd0);
    send(gjsc_pkg::OP_TO_SECONDS, -22'sd4713, 4'd11, 5'd23, -32'sd1, -64'sd1);
    send(gjsc_pkg::OP_TO_SECONDS, 22'sd1470000, 4'd12, 5'd31, 32'h7fffffff, 64'sd0);
    send(gjsc_pkg::OP_TO_SECONDS, 22'sh1fffff, 4'd15, 5'd31, 32'h80000000, 64'sd0);
    send(gjsc_pkg::OP_TO_SECONDS, 22'sh200000, 4'd0, 5'd0, 32'sd1, 64'sd0);
    send(gjsc_pkg::OP_TO_SECONDS, 22'sd2000, 4'd2, 5'd29, 32'sd2451545, 64'sd0);
    send(gjsc_pkg::OP_TO_DATE, 22'sd0, 4'd1, 5'd1, 32'sd0, 64'sd0);
    send(gjsc_pkg::OP_TO_DATE, 22'sd0, 4'd1, 5'd1, 32'sd0, -64'sd1);
    send(gjsc_pkg::OP_TO_DATE, 22'sd0, 4'd1, 5'd1, 32'sd0, -spd);
    send(gjsc_pkg::OP_TO_DATE, 22'sd0, 4'd1, 5'd1, 32'sd0,
         gjsc_pkg::GREG_DAY_MAX * spd + spd - 1);
    send(gjsc_pkg::OP_TO_DATE, 22'sd0, 4'd1, 5'd1, 32'sd0,
         (gjsc_pkg::GREG_DAY_MAX + 1) * spd);
    send(gjsc_pkg::OP_TO_DATE, 22'sd0, 4'd1, 5'd1, 32'sd0, 64'sd2147483647 * spd);
    send(gjsc_pkg::OP_TO_DATE, 22'sd0, 4'd1, 5'd1, 32'sd0, 64'sd2147483648 * spd);
    send(gjsc_pkg::OP_TO_DATE, 22'sd0, 4'd1, 5'd1, 32'sd0, -64'sd2147483648 * spd);
    send(gjsc_pkg::OP_TO_DATE, 22'sd0, 4'd1, 5'd1, 32'sd0, 64'h7fffffffffffffff);
    send(gjsc_pkg::OP_TO_DATE, 22'sd0, 4'd1, 5'd1, 32'sd0, 64'h8000000000000000);
  endtask

  task automatic random_item();
    logic signed [21:0] yr;
    logic [3:0]         mo;
    logic [4:0]         dy;
    logic signed [31:0] jin;
    logic signed [63:0] secs;
    longint             spd;
    spd = longint'(spd_now);
    yr = ($urandom_range(9) < 8) ? 22'(longint'($urandom_range(1474713)) - 4713) : 22'($urandom);
    mo = ($urandom_range(9) < 8) ? 4'($urandom_range(12, 1)) : 4'($urandom);
    dy = ($urandom_range(9) < 8) ? 5'($urandom_range(31, 1)) : 5'($urandom);
    jin = $urandom;
    case ($urandom_range(3))
      0: secs = {$urandom, $urandom};
      1: secs = longint'(jin) * spd + longint'($urandom_range(spd > 0 ? spd - 1 : 0));
      default: secs = longint'($urandom_range(gjsc_pkg::GREG_DAY_MAX)) * spd
                      + longint'($urandom_range(spd > 0 ? spd - 1 : 0));
    endcase
    send(1'($urandom), yr, mo, dy, jin, secs);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (gjsc_pkg::TOTAL_LAT + 4) @(posedge clk);
  endtask

  initial begin
    logic [1:0]                 modes[11];
    logic [gjsc_pkg::SPD_W-1:0] spds[11];
    modes = '{gjsc_pkg::MODE_NONE, gjsc_pkg::MODE_GREGORIAN, gjsc_pkg::MODE_GREGORIAN,
              gjsc_pkg::MODE_JULIAN, gjsc_pkg::MODE_JULIAN, 2'd3,
              gjsc_pkg::MODE_GREGORIAN, gjsc_pkg::MODE_GREGORIAN, gjsc_pkg::MODE_JULIAN,
              gjsc_pkg::MODE_JULIAN, gjsc_pkg::MODE_GREGORIAN};
    spds = '{17'd86400, 17'd86400, 17'd1, 17'd86400, 17'd131071,
             17'd100, 17'd131071, 17'd0, 17'd0, 17'd1, 17'd86400};
    rst = 1'b1;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = gjsc_pkg::CFG_MODE;
    cfg_data = '0;
    operation = gjsc_pkg::OP_TO_SECONDS;
    year_in = '0;
    month_in = 4'd1;
    day_in = 5'd1;
    julian_day_in = '0;
    seconds_in = '0;
    spd_now = gjsc_pkg::SPD_RESET;
    calm = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < 11; p++) begin
      if (p > 0) begin
        write_reg(gjsc_pkg::CFG_MODE, 17'(modes[p]));
        write_reg(gjsc_pkg::CFG_SPD, (p == 10) ? 17'($urandom_range(131071, 1)) : spds[p]);
        cfg_valid <= 1'b0;
      end
      calm = (p == 10);
      directed_items();
      repeat (22) random_item();
      drain();
    end
    if (errors == 0)
      $display("** gregorian_julian_seconds_converter: PASSED **");
    else
      $display("** gregorian_julian_seconds_converter: FAILED **");
    $finish;
  end

endmodule

[gregorian_julian_seconds_converter.f]
rtl/gjsc_pkg.sv
rtl/gjsc_div.sv
rtl/gjsc_fwd.sv
rtl/gjsc_inv.sv
rtl/gregorian_julian_seconds_converter.sv
verif/gjsc_checker.sv
verif/gregorian_julian_seconds_converter_test.sv
